FILE: rtl/pmat_pkg.sv
// ----------------------------------------------------------------------------
// pmat_pkg
// Shared constants, codes, types and helper functions for the paged memory
// allocator and translator.
// ----------------------------------------------------------------------------
package pmat_pkg;

   // geometry
   localparam int PAGE_OFFSET_BITS = 12;
   localparam int PHYS_PAGES       = 1024;
   localparam int PROCESSES        = 16;
   localparam int TABLE_DEPTH      = 256;

   localparam int PAGE_BITS = $clog2(PHYS_PAGES);
   localparam int MODE_W    = 2;
   localparam int PID_W     = 4;
   localparam int CNT_W     = 11;
   localparam int VADDR_W   = 32;
   localparam int VPAGE_W   = VADDR_W - PAGE_OFFSET_BITS;
   localparam int STATUS_W  = 3;
   localparam int RADDR_W   = 22;
   localparam int STAT_W    = 32;

   localparam logic [CNT_W-1:0] RESET_TOTAL = 11'd1024;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_XLATE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTABLE = 3'd5;

   // access to the used-page bitmap
   typedef struct packed {
      logic                 rd_en;
      logic [PAGE_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [PAGE_BITS-1:0] wr_addr;
      logic                 wr_bit;
   } bmp_req_type;

   // clamp the page total to the bitmap depth
   function automatic logic [CNT_W-1:0] eff_total(input logic [CNT_W-1:0] t);
      logic [CNT_W-1:0] lim;
      lim = CNT_W'(PHYS_PAGES);
      return (t > lim) ? lim : t;
   endfunction

   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
      return (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
   endfunction

   function automatic logic [RADDR_W-1:0] page_addr(
      input logic [PAGE_BITS-1:0]        pg,
      input logic [PAGE_OFFSET_BITS-1:0] off
   );
      logic [PAGE_BITS+PAGE_OFFSET_BITS-1:0] full;
      full = {pg, off};
      return RADDR_W'(full);
   endfunction

endpackage

FILE: rtl/pmat_bitmap.sv
// ----------------------------------------------------------------------------
// pmat_bitmap
// Used-page bitmap: one bit per physical page in a synchronous memory with a
// registered read, plus a sweep that clears every page after reset or on
// request.
// ----------------------------------------------------------------------------
module pmat_bitmap (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  pmat_pkg::bmp_req_type  req,
   output logic                   rd_bit,
   output logic                   clearing
);

   logic                           mem [pmat_pkg::PHYS_PAGES];
   logic                           rd_bit_ff;
   logic                           clr_busy_ff;
   logic                           clr_busy_in;
   logic [pmat_pkg::PAGE_BITS-1:0] clr_addr_ff;
   logic [pmat_pkg::PAGE_BITS-1:0] clr_addr_in;

   // advance the clearing sweep
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clear) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == pmat_pkg::PAGE_BITS'(pmat_pkg::PHYS_PAGES - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + pmat_pkg::PAGE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // bitmap memory: the sweep owns the write port while it runs
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_bit;
      end
      if (req.rd_en) begin
         rd_bit_ff <= mem[req.rd_addr];
      end
   end

   assign rd_bit   = rd_bit_ff;
   assign clearing = clr_busy_ff;

endmodule

FILE: rtl/paged_memory_allocator_translator.sv
// ----------------------------------------------------------------------------
// paged_memory_allocator_translator
// First-fit page allocator over a used-page bitmap with one linear page table
// per process; allocates runs, frees whole processes and translates addresses.
// ----------------------------------------------------------------------------
// Usage: raise start with a word on req_*; it is taken when busy is low. One
// result word appears on rsp_* for exactly one cycle with rsp_strobe high and
// cannot be held off, so capture it on that cycle. Operations run one at a
// time. Allocate scans the bitmap one page per cycle and then writes one page
// per cycle for the run. Free reads each table entry, then its bitmap bit, and
// then releases the page. Translate reads one table entry per cycle until it
// hits; a miss then runs the allocate scan for one page. Rejected requests
// answer on the next cycle. After reset, and after every csr write, a clearing
// pass over all PHYS_PAGES (1024) pages sweeps the bitmap with busy held high;
// a csr write also clears all tables and the fault, hit and miss counters.
// ----------------------------------------------------------------------------
module paged_memory_allocator_translator #(
   parameter int TABLE_DEPTH = pmat_pkg::TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [pmat_pkg::MODE_W-1:0]         req_mode,
   input  logic [pmat_pkg::PID_W-1:0]          req_pid,
   input  logic [pmat_pkg::CNT_W-1:0]          req_page_count,
   input  logic [pmat_pkg::VADDR_W-1:0]        req_vaddr,
   // result
   output logic                                rsp_strobe,
   output logic [pmat_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pmat_pkg::RADDR_W-1:0]        rsp_result_addr,
   output logic [pmat_pkg::CNT_W-1:0]          rsp_free_page_count,
   output logic [pmat_pkg::STAT_W-1:0]         rsp_fault_count,
   output logic [pmat_pkg::STAT_W-1:0]         rsp_hit_count,
   output logic [pmat_pkg::STAT_W-1:0]         rsp_miss_count,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pmat_pkg::CNT_W-1:0]          csr_data
);

   localparam int FILL_W    = $clog2(TABLE_DEPTH + 1);
   localparam int TIDX_W    = $clog2(TABLE_DEPTH);
   localparam int ENT_AW    = pmat_pkg::PID_W + TIDX_W;
   localparam int ENT_DEPTH = pmat_pkg::PROCESSES << TIDX_W;
   localparam int ENT_W     = pmat_pkg::VPAGE_W + pmat_pkg::PAGE_BITS;
   localparam int SUM_W     = ((FILL_W > pmat_pkg::CNT_W) ? FILL_W : pmat_pkg::CNT_W) + 1;
   localparam int PB        = pmat_pkg::PAGE_BITS;
   localparam int CW        = pmat_pkg::CNT_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_COMMIT  = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd3;
   localparam logic [2:0] S_FREE_BM = 3'd4;
   localparam logic [2:0] S_FREE_WR = 3'd5;
   localparam logic [2:0] S_LOOK    = 3'd6;

   // control and statistics
   logic [2:0]                            state_ff, state_in;
   logic [CW-1:0]                         total_ff, total_in;
   logic [CW-1:0]                         free_ff, free_in;
   logic [pmat_pkg::STAT_W-1:0]           fault_ff, fault_in;
   logic [pmat_pkg::STAT_W-1:0]           hit_ff, hit_in;
   logic [pmat_pkg::STAT_W-1:0]           miss_ff, miss_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                         scan_addr_ff, scan_addr_in;
   logic                                  rd_vld_ff, rd_vld_in;
   logic [CW-1:0]                         run_ff, run_in;
   logic [CW-1:0]                         j_ff, j_in;
   logic [FILL_W-1:0]                     k_ff, k_in;

   // per-item payload registers
   logic [pmat_pkg::PID_W-1:0]            pid_ff, pid_in;
   logic [CW-1:0]                         count_ff, count_in;
   logic [pmat_pkg::VPAGE_W-1:0]          vpage_ff, vpage_in;
   logic [pmat_pkg::PAGE_OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                                  fixed_ff, fixed_in;
   logic [FILL_W-1:0]                     fill_ff, fill_in;
   logic [PB-1:0]                         rd_idx_ff, rd_idx_in;
   logic [PB-1:0]                         start_ff, start_in;
   logic [pmat_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [pmat_pkg::RADDR_W-1:0]          rsp_addr_ff, rsp_addr_in;

   // per-process table heads
   logic                                  tbl_exists_ff [pmat_pkg::PROCESSES];
   logic [FILL_W-1:0]                     tbl_fill_ff   [pmat_pkg::PROCESSES];
   logic                                  tbl_we;
   logic                                  tbl_exists_wd;
   logic [FILL_W-1:0]                     tbl_fill_wd;

   // page table entry memory
   logic [ENT_W-1:0]                      ent_mem [ENT_DEPTH];
   logic [ENT_W-1:0]                      ent_rd_ff;
   logic                                  ent_rd_en;
   logic [ENT_AW-1:0]                     ent_rd_addr;
   logic                                  ent_wr_en;
   logic [ENT_AW-1:0]                     ent_wr_addr;
   logic [ENT_W-1:0]                      ent_wr_data;

   // bitmap access
   pmat_pkg::bmp_req_type                 bm_req;
   logic                                  bm_rd_bit;
   logic                                  bm_clearing;

   logic                                  pid_ok;
   logic [CW-1:0]                         limit;
   logic [CW-1:0]                         run_nx;
   logic                                  found;
   logic                                  tbl_full;
   logic [SUM_W-1:0]                      pos;
   logic [SUM_W-1:0]                      fill_sum;

   pmat_bitmap u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_valid),
      .req      (bm_req),
      .rd_bit   (bm_rd_bit),
      .clearing (bm_clearing)
   );

   assign busy      = (state_ff != S_IDLE) || bm_clearing;
   assign csr_ready = 1'b1;
   assign pid_ok    = ({1'b0, req_pid} < (pmat_pkg::PID_W + 1)'(pmat_pkg::PROCESSES));
   assign limit     = pmat_pkg::eff_total(total_ff);
   assign fill_sum  = SUM_W'(fill_ff) + SUM_W'(count_ff);
   assign tbl_full  = (fill_sum > SUM_W'(TABLE_DEPTH));
   assign pos       = SUM_W'(fill_ff) + SUM_W'(j_ff);

   // sequence one operation at a time
   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      fault_in      = fault_ff;
      hit_in        = hit_ff;
      miss_in       = miss_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      scan_addr_in  = scan_addr_ff;
      rd_vld_in     = rd_vld_ff;
      run_in        = run_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      pid_in        = pid_ff;
      count_in      = count_ff;
      vpage_in      = vpage_ff;
      offset_in     = offset_ff;
      fixed_in      = fixed_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      bm_req        = '0;
      ent_rd_en     = 1'b0;
      ent_rd_addr   = {pid_ff, k_ff[TIDX_W-1:0]};
      ent_wr_en     = 1'b0;
      ent_wr_addr   = {pid_ff, pos[TIDX_W-1:0]};
      ent_wr_data   = '0;
      tbl_we        = 1'b0;
      tbl_exists_wd = 1'b0;
      tbl_fill_wd   = '0;
      run_nx        = run_ff + CW'(1);
      found         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               pid_in       = req_pid;
               count_in     = req_page_count;
               vpage_in     = req_vaddr[pmat_pkg::VADDR_W-1:pmat_pkg::PAGE_OFFSET_BITS];
               offset_in    = req_vaddr[pmat_pkg::PAGE_OFFSET_BITS-1:0];
               fill_in      = tbl_fill_ff[req_pid];
               fixed_in     = 1'b0;
               scan_addr_in = '0;
               run_in       = '0;
               rd_vld_in    = 1'b0;
               k_in         = '0;
               rsp_addr_in  = '0;
               case (req_mode)
                  pmat_pkg::MODE_ALLOC: begin
                     if (!pid_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pmat_pkg::ST_NOTABLE;
                     end else if (req_page_count == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pmat_pkg::ST_ZERO;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  pmat_pkg::MODE_FREE: begin
                     if (!pid_ok || !tbl_exists_ff[req_pid]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pmat_pkg::ST_NOTABLE;
                     end else begin
                        state_in = S_FREE_RD;
                     end
                  end
                  pmat_pkg::MODE_XLATE: begin
                     if (!pid_ok || !tbl_exists_ff[req_pid]) begin
                        fault_in      = pmat_pkg::sat_inc(fault_ff);
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pmat_pkg::ST_NOTABLE;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pmat_pkg::ST_OK;
                  end
               endcase
            end
         end

         // stream the bitmap, one page per cycle, tracking the free run
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (!bm_rd_bit) begin
                  start_in = (run_ff == '0) ? rd_idx_ff : start_ff;
                  run_in   = run_nx;
                  found    = (run_nx == count_ff);
               end else begin
                  run_in = '0;
               end
            end
            if (found) begin
               rd_vld_in = 1'b0;
               if (tbl_full) begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pmat_pkg::ST_FULL;
                  rsp_addr_in   = '0;
               end else begin
                  state_in = S_COMMIT;
                  j_in     = '0;
               end
            end else if (scan_addr_ff < limit) begin
               bm_req.rd_en   = 1'b1;
               bm_req.rd_addr = scan_addr_ff[PB-1:0];
               rd_vld_in      = 1'b1;
               rd_idx_in      = scan_addr_ff[PB-1:0];
               scan_addr_in   = scan_addr_ff + CW'(1);
            end else begin
               rd_vld_in = 1'b0;
               if (!rd_vld_ff) begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = pmat_pkg::ST_NOSPACE;
                  rsp_addr_in   = '0;
               end
            end
         end

         // mark one page used and append its table entry per cycle
         S_COMMIT: begin
            bm_req.wr_en   = 1'b1;
            bm_req.wr_addr = start_ff + j_ff[PB-1:0];
            bm_req.wr_bit  = 1'b1;
            ent_wr_en      = 1'b1;
            ent_wr_data    = {(fixed_ff ? vpage_ff : pmat_pkg::VPAGE_W'(pos)),
                              start_ff + j_ff[PB-1:0]};
            j_in           = j_ff + CW'(1);
            if ((j_ff + CW'(1)) == count_ff) begin
               tbl_we        = 1'b1;
               tbl_exists_wd = 1'b1;
               tbl_fill_wd   = FILL_W'(fill_sum);
               free_in       = free_ff - count_ff;
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = fixed_ff ? pmat_pkg::ST_FAULT : pmat_pkg::ST_OK;
               rsp_addr_in   = pmat_pkg::page_addr(start_ff,
                                  fixed_ff ? offset_ff : '0);
            end
         end

         // free: read entry, read its bitmap bit, release it
         S_FREE_RD: begin
            if (k_ff == fill_ff) begin
               tbl_we        = 1'b1;
               tbl_exists_wd = 1'b0;
               tbl_fill_wd   = '0;
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pmat_pkg::ST_OK;
               rsp_addr_in   = '0;
            end else begin
               ent_rd_en = 1'b1;
               state_in  = S_FREE_BM;
            end
         end

         S_FREE_BM: begin
            bm_req.rd_en   = 1'b1;
            bm_req.rd_addr = ent_rd_ff[PB-1:0];
            state_in       = S_FREE_WR;
         end

         S_FREE_WR: begin
            if (bm_rd_bit) begin
               bm_req.wr_en   = 1'b1;
               bm_req.wr_addr = ent_rd_ff[PB-1:0];
               bm_req.wr_bit  = 1'b0;
               free_in        = free_ff + CW'(1);
            end
            k_in     = k_ff + FILL_W'(1);
            state_in = S_FREE_RD;
         end

         // search the table in order, one entry per cycle
         S_LOOK: begin
            if (rd_vld_ff && (ent_rd_ff[ENT_W-1:PB] == vpage_ff)) begin
               hit_in        = pmat_pkg::sat_inc(hit_ff);
               rd_vld_in     = 1'b0;
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pmat_pkg::ST_OK;
               rsp_addr_in   = pmat_pkg::page_addr(ent_rd_ff[PB-1:0], offset_ff);
            end else if (k_ff < fill_ff) begin
               ent_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               k_in      = k_ff + FILL_W'(1);
            end else begin
               rd_vld_in = 1'b0;
               if (!rd_vld_ff) begin
                  fault_in     = pmat_pkg::sat_inc(fault_ff);
                  miss_in      = pmat_pkg::sat_inc(miss_ff);
                  count_in     = CW'(1);
                  fixed_in     = 1'b1;
                  scan_addr_in = '0;
                  run_in       = '0;
                  state_in     = S_SCAN;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers; a csr word reinitializes the allocator
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= pmat_pkg::RESET_TOTAL;
         free_ff      <= pmat_pkg::eff_total(pmat_pkg::RESET_TOTAL);
         fault_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         run_ff       <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         for (int p = 0; p < pmat_pkg::PROCESSES; p++) begin
            tbl_exists_ff[p] <= 1'b0;
            tbl_fill_ff[p]   <= '0;
         end
      end else if (csr_valid) begin
         state_ff     <= S_IDLE;
         total_ff     <= csr_data;
         free_ff      <= pmat_pkg::eff_total(csr_data);
         fault_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         for (int p = 0; p < pmat_pkg::PROCESSES; p++) begin
            tbl_exists_ff[p] <= 1'b0;
            tbl_fill_ff[p]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         fault_ff     <= fault_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_addr_ff <= scan_addr_in;
         rd_vld_ff    <= rd_vld_in;
         run_ff       <= run_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         if (tbl_we) begin
            tbl_exists_ff[pid_ff] <= tbl_exists_wd;
            tbl_fill_ff[pid_ff]   <= tbl_fill_wd;
         end
      end
   end

   // hold the item payload
   always_ff @(posedge clock) begin
      pid_ff        <= pid_in;
      count_ff      <= count_in;
      vpage_ff      <= vpage_in;
      offset_ff     <= offset_in;
      fixed_ff      <= fixed_in;
      fill_ff       <= fill_in;
      rd_idx_ff     <= rd_idx_in;
      start_ff      <= start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // page table entry memory
   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      if (ent_rd_en) begin
         ent_rd_ff <= ent_mem[ent_rd_addr];
      end
   end

   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_addr     = rsp_addr_ff;
   assign rsp_free_page_count = free_ff;
   assign rsp_fault_count     = fault_ff;
   assign rsp_hit_count       = hit_ff;
   assign rsp_miss_count      = miss_ff;

   // a result word only leaves once the sequencer is back at rest
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while an operation is still running");

   // an accepted word either answers at once or starts an operation
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_valid) |=> (rsp_valid_ff || (state_ff != S_IDLE)))
      else $error("accepted request word was dropped");

   // free pages never exceed the clamped page total
   a_free_bound : assert property (@(posedge clock) disable iff (reset)
      free_ff <= pmat_pkg::eff_total(total_ff))
      else $error("free page count above the page total");

endmodule
